/* rtl/sctc_pkg.sv */
`default_nettype none

package sctc_pkg;

  localparam int ADDR_BITS     = 32;
  localparam int TABLE_ENTRIES = 64;

  localparam int OP_BITS  = 3;
  localparam int MSG_BITS = 2;
  localparam int BOB_BITS = 4;
  localparam int REG_BITS = 2;

  localparam logic [OP_BITS-1:0] OP_BUS_READ_MISS  = 3'd0;
  localparam logic [OP_BITS-1:0] OP_BUS_WRITE      = 3'd1;
  localparam logic [OP_BITS-1:0] OP_LOCAL_WRITE    = 3'd2;
  localparam logic [OP_BITS-1:0] OP_LOCAL_READ     = 3'd3;
  localparam logic [OP_BITS-1:0] OP_LOCAL_WB       = 3'd4;

  localparam logic [MSG_BITS-1:0] MSG_NONE       = 2'd0;
  localparam logic [MSG_BITS-1:0] MSG_READ_MISS  = 2'd1;
  localparam logic [MSG_BITS-1:0] MSG_WRITE_MISS = 2'd2;

  localparam logic [REG_BITS-1:0] REG_COHERENT_ENABLE      = 2'd0;
  localparam logic [REG_BITS-1:0] REG_FIRST_LEVEL_PRESENT  = 2'd1;
  localparam logic [REG_BITS-1:0] REG_SECOND_LEVEL_PRESENT = 2'd2;
  localparam logic [REG_BITS-1:0] REG_BLOCK_OFFSET_BITS    = 2'd3;

  // Running summary handed from one cell to the next.
  typedef struct packed {
    logic free_before;
    logic hit;
    logic hit_excl;
  } cell_link_t;

  // Command broadcast to every cell.
  typedef struct packed {
    logic                 update;
    logic [ADDR_BITS-1:0] block;
    logic                 inval;
    logic                 set_excl;
    logic                 clr_excl;
    logic                 alloc;
    logic                 alloc_excl;
  } cell_cmd_t;

endpackage

`default_nettype wire

/* rtl/sctc_cell.sv */
`default_nettype none

module sctc_cell (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           query_valid,
  input  wire  [sctc_pkg::ADDR_BITS-1:0] query_block,
  input  wire  sctc_pkg::cell_cmd_t     cmd,
  input  wire  sctc_pkg::cell_link_t    link_in,
  output sctc_pkg::cell_link_t          link_out
);

  logic                          valid;
  logic [sctc_pkg::ADDR_BITS-1:0] block;
  logic                          excl;
  logic                          hit;
  logic                          free;
  logic                          take;

  assign hit  = query_valid && valid && (block == query_block);
  assign free = !valid;
  // Lowest free slot: free here and nothing free below.
  assign take = cmd.update && cmd.alloc && free && !link_in.free_before;

  always_comb begin
    link_out.free_before = link_in.free_before | free;
    link_out.hit         = link_in.hit | hit;
    link_out.hit_excl    = link_in.hit_excl | (hit & excl);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.update) begin
      if (hit && cmd.inval) begin
        valid <= 1'b0;
      end else if (take) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      block <= cmd.block;
      excl  <= cmd.alloc_excl;
    end else if (cmd.update && hit) begin
      if (cmd.set_excl) begin
        excl <= 1'b1;
      end else if (cmd.clr_excl) begin
        excl <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/sctc_chain.sv */
`default_nettype none

module sctc_chain (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           query_valid,
  input  wire  [sctc_pkg::ADDR_BITS-1:0] query_block,
  input  wire  sctc_pkg::cell_cmd_t     cmd,
  output sctc_pkg::cell_link_t          summary
);

  sctc_pkg::cell_link_t links [sctc_pkg::TABLE_ENTRIES+1];

  assign links[0] = '0;

  for (genvar i = 0; i < sctc_pkg::TABLE_ENTRIES; i++) begin : g_cell
    sctc_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .query_valid (query_valid),
      .query_block (query_block),
      .cmd         (cmd),
      .link_in     (links[i]),
      .link_out    (links[i+1])
    );
  end

  assign summary = links[sctc_pkg::TABLE_ENTRIES];

endmodule

`default_nettype wire

/* rtl/snoop_coherence_tag_controller_top.sv */
`default_nettype none

// Snooping write-invalidate coherence tag keeper. Each request (bus read miss,
// bus write miss or hit, local write, local read miss, local write-back) is
// matched against a row of 64 tag cells, each holding one block address with
// a shared/exclusive mark; the cells hand a running hit/free summary to their
// neighbor so the row answers combinationally and the lowest free cell takes a
// new block. A request is first registered with its block address, then matched
// across the cell row with the tag update once the output register can take its
// result; no new request is taken until the held one has executed. The next
// request is taken while a result still waits in the output register. Exactly
// one result leaves for every request. All cells are empty after reset; no
// clearing pass is needed. Configuration must be written through the cfg channel
// (always ready) only while the block is idle; the block does not enforce it.

module snoop_coherence_tag_controller_top (
  input  wire         clk,
  input  wire         rst,
  // request stream
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] address, [32] first_level_holds, [33] second_level_holds, [39:34] zero
  input  wire  [39:0] s_axis_tdata,
  // [2:0] opcode
  input  wire  [2:0]  s_axis_tuser,
  // result stream
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // [31:0] message_block, [32] write_back, [64:33] write_back_addr,
  // [65] invalidate_first, [66] invalidate_second, [67] table_overflow, [71:68] zero
  output logic [71:0] m_axis_tdata,
  // [1:0] bus_message
  output logic [1:0]  m_axis_tuser,
  // configuration writes
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [3:0]  cfg_data
);

  localparam int AW = sctc_pkg::ADDR_BITS;

  // Configuration registers.
  logic                            coherent_enable;
  logic                            first_level_present;
  logic                            second_level_present;
  logic [sctc_pkg::BOB_BITS-1:0]   block_offset_bits;

  // Pending request stage.
  logic                            pend;
  logic [sctc_pkg::OP_BITS-1:0]    req_op;
  logic [AW-1:0]                   req_addr;
  logic [AW-1:0]                   req_block;
  logic                            req_h1;
  logic                            req_h2;

  // Output register.
  logic [sctc_pkg::MSG_BITS-1:0]   out_msg;
  logic [AW-1:0]                   out_mblk;
  logic                            out_wb;
  logic [AW-1:0]                   out_wba;
  logic                            out_inv1;
  logic                            out_inv2;
  logic                            out_ovf;

  logic [sctc_pkg::MSG_BITS-1:0]   out_msg_next;
  logic [AW-1:0]                   out_mblk_next;
  logic                            out_wb_next;
  logic [AW-1:0]                   out_wba_next;
  logic                            out_inv1_next;
  logic                            out_inv2_next;
  logic                            out_ovf_next;

  logic                            accept;
  logic                            fire;
  logic [AW-1:0]                   in_addr;
  logic [AW-1:0]                   block_mask;
  logic                            addr_nz;
  logic                            excl_ok;

  sctc_pkg::cell_cmd_t             cmd;
  sctc_pkg::cell_link_t            summary;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !pend;
  assign accept        = s_axis_tvalid && s_axis_tready;
  // Execute the held request once the output register can take its result.
  assign fire          = pend && (!m_axis_tvalid || m_axis_tready);

  assign in_addr = s_axis_tdata[AW-1:0];

  // Clear the block offset bits only when some cache defines a block.
  always_comb begin
    if (first_level_present || second_level_present) begin
      block_mask = ~((AW'(1) << block_offset_bits) - AW'(1));
    end else begin
      block_mask = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coherent_enable      <= 1'b1;
      first_level_present  <= 1'b1;
      second_level_present <= 1'b1;
      block_offset_bits    <= sctc_pkg::BOB_BITS'(6);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sctc_pkg::REG_COHERENT_ENABLE:      coherent_enable      <= cfg_data[0];
        sctc_pkg::REG_FIRST_LEVEL_PRESENT:  first_level_present  <= cfg_data[0];
        sctc_pkg::REG_SECOND_LEVEL_PRESENT: second_level_present <= cfg_data[0];
        sctc_pkg::REG_BLOCK_OFFSET_BITS:    block_offset_bits    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold the request and its block address until it executes.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (accept) begin
      pend <= 1'b1;
    end else if (fire) begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op    <= s_axis_tuser;
      req_addr  <= in_addr;
      req_block <= in_addr & block_mask;
      req_h1    <= s_axis_tdata[AW];
      req_h2    <= s_axis_tdata[AW+1];
    end
  end

  sctc_chain u_chain (
    .clk         (clk),
    .rst         (rst),
    .query_valid (pend),
    .query_block (req_block),
    .cmd         (cmd),
    .summary     (summary)
  );

  assign addr_nz = (req_addr != '0);

  // Decide the result and the cell command from the row summary.
  always_comb begin
    cmd            = '0;
    cmd.update     = fire;
    cmd.block      = req_block;
    out_msg_next   = sctc_pkg::MSG_NONE;
    out_mblk_next  = '0;
    out_wb_next    = 1'b0;
    out_wba_next   = '0;
    out_inv1_next  = 1'b0;
    out_inv2_next  = 1'b0;
    out_ovf_next   = 1'b0;
    excl_ok        = 1'b0;
    case (req_op)
      sctc_pkg::OP_BUS_READ_MISS: begin
        // Demote an exclusive block to shared with a write-back.
        if (addr_nz && summary.hit_excl) begin
          out_wb_next  = 1'b1;
          out_wba_next = req_addr;
          cmd.clr_excl = 1'b1;
        end
      end
      sctc_pkg::OP_BUS_WRITE: begin
        if (addr_nz && summary.hit) begin
          cmd.inval = 1'b1;
          if (first_level_present) begin
            out_inv1_next = req_h1;
            out_inv2_next = second_level_present && req_h2;
            excl_ok       = req_h1 || (second_level_present && req_h2);
            if (summary.hit_excl && excl_ok) begin
              out_wb_next  = 1'b1;
              out_wba_next = req_addr;
            end
          end
        end
      end
      sctc_pkg::OP_LOCAL_WRITE: begin
        if (coherent_enable && addr_nz) begin
          if (summary.hit) begin
            // Post a write miss only when exclusivity is gained.
            if (!summary.hit_excl) begin
              out_msg_next  = sctc_pkg::MSG_WRITE_MISS;
              out_mblk_next = req_block;
              cmd.set_excl  = 1'b1;
            end
          end else begin
            out_msg_next   = sctc_pkg::MSG_WRITE_MISS;
            out_mblk_next  = req_block;
            cmd.alloc      = 1'b1;
            cmd.alloc_excl = 1'b1;
            out_ovf_next   = !summary.free_before;
          end
        end
      end
      sctc_pkg::OP_LOCAL_READ, sctc_pkg::OP_LOCAL_WB: begin
        if (coherent_enable) begin
          if (summary.hit) begin
            cmd.clr_excl = 1'b1;
          end else begin
            cmd.alloc    = 1'b1;
            out_ovf_next = !summary.free_before;
          end
          if (req_op == sctc_pkg::OP_LOCAL_READ) begin
            out_msg_next  = sctc_pkg::MSG_READ_MISS;
            out_mblk_next = req_block;
          end
        end
      end
      default: ;
    endcase
  end

  // Advance the result into the output register; drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_msg  <= out_msg_next;
      out_mblk <= out_mblk_next;
      out_wb   <= out_wb_next;
      out_wba  <= out_wba_next;
      out_inv1 <= out_inv1_next;
      out_inv2 <= out_inv2_next;
      out_ovf  <= out_ovf_next;
    end
  end

  assign m_axis_tuser = out_msg;
  assign m_axis_tdata = {4'b0000, out_ovf, out_inv2, out_inv1, out_wba, out_wb, out_mblk};

endmodule

`default_nettype wire
